// ===== rtl/core/ccbe_pkg.sv =====
// Shared types, codes and helpers for the configurable CRC byte engine.
package ccbe_pkg;

  // Field and register widths
  localparam int unsigned CRC_W   = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned NWID_W  = 4;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CIDX_W  = 3;

  // Width mode codes
  localparam logic [MODE_W-1:0] WMODE_NARROW = 2'd0;
  localparam logic [MODE_W-1:0] WMODE_16     = 2'd1;
  localparam logic [MODE_W-1:0] WMODE_32     = 2'd2;
  localparam logic [MODE_W-1:0] WMODE_64     = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WIDTH_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_NARROW_WIDTH = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_POLYNOMIAL   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SEED_VALUE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_REFLECTED    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [MODE_W-1:0] WIDTH_MODE_RST   = WMODE_32;
  localparam logic [NWID_W-1:0] NARROW_WIDTH_RST = 4'd8;

  // Engine setup in working form, handed from the prep logic to the fold
  typedef struct packed {
    logic [MODE_W-1:0]  width_mode;
    logic               reflected;
    logic [SHIFT_W-1:0] narrow_shift;
    logic [CRC_W-1:0]   poly_work;
    logic [CRC_W-1:0]   seed_work;
  } eng_cfg_t;

  // Mask of the active engine width (narrow runs as an 8-bit engine)
  function automatic logic [CRC_W-1:0] width_mask(input logic [MODE_W-1:0] mode);
    logic [CRC_W-1:0] m;
    case (mode)
      WMODE_NARROW: m = 64'h0000_0000_0000_00FF;
      WMODE_16:     m = 64'h0000_0000_0000_FFFF;
      WMODE_32:     m = 64'h0000_0000_FFFF_FFFF;
      WMODE_64:     m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:      m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/ccbe_prep.sv =====
// Brings polynomial and seed into the engine's working form.
module ccbe_prep (
  input  logic [ccbe_pkg::MODE_W-1:0] width_mode,
  input  logic [ccbe_pkg::NWID_W-1:0] narrow_width,
  input  logic [ccbe_pkg::CRC_W-1:0]  polynomial,
  input  logic [ccbe_pkg::CRC_W-1:0]  seed_value,
  input  logic                        reflected,
  output ccbe_pkg::eng_cfg_t          eng_cfg
);
  import ccbe_pkg::*;

  logic [SHIFT_W-1:0] shift;
  logic [BYTE_W-1:0]  nmask;

  // Narrow alignment shift: widths of eight and above need none
  assign shift = (narrow_width >= NWID_W'(8)) ? '0 : (SHIFT_W'(8) - narrow_width);
  assign nmask = 8'hFF >> shift;

  always_comb begin
    eng_cfg.width_mode   = width_mode;
    eng_cfg.reflected    = reflected;
    eng_cfg.narrow_shift = shift;
    if (width_mode == WMODE_NARROW) begin
      if (reflected) begin
        // LSB first: mask to the width
        eng_cfg.poly_work = {56'd0, polynomial[BYTE_W-1:0] & nmask};
        eng_cfg.seed_work = {56'd0, seed_value[BYTE_W-1:0] & nmask};
      end else begin
        // MSB first: left-align within the byte
        eng_cfg.poly_work = {56'd0, polynomial[BYTE_W-1:0] << shift};
        eng_cfg.seed_work = {56'd0, seed_value[BYTE_W-1:0] << shift};
      end
    end else begin
      eng_cfg.poly_work = polynomial & width_mask(width_mode);
      eng_cfg.seed_work = seed_value & width_mask(width_mode);
    end
  end

endmodule

// ===== rtl/core/ccbe_fold.sv =====
// Folds one byte into the CRC register: eight unrolled shift/XOR steps.
module ccbe_fold (
  input  ccbe_pkg::eng_cfg_t          eng_cfg,
  input  logic [ccbe_pkg::CRC_W-1:0]  crc_cur,
  input  logic [ccbe_pkg::BYTE_W-1:0] data_byte,
  input  logic                        first_byte,
  output logic [ccbe_pkg::CRC_W-1:0]  crc_next,
  output logic [ccbe_pkg::CRC_W-1:0]  crc_out
);
  import ccbe_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] r;
    logic [CRC_W-1:0] byte_al;
    logic             fb;
    mask = width_mask(eng_cfg.width_mode);
    r    = (first_byte ? eng_cfg.seed_work : crc_cur) & mask;

    // Byte lands at the top of the active width in normal mode
    case (eng_cfg.width_mode)
      WMODE_NARROW: byte_al = {56'd0, data_byte};
      WMODE_16:     byte_al = {48'd0, data_byte, 8'd0};
      WMODE_32:     byte_al = {32'd0, data_byte, 24'd0};
      WMODE_64:     byte_al = {data_byte, 56'd0};
      default:      byte_al = {data_byte, 56'd0};
    endcase

    if (eng_cfg.reflected) begin
      r = r ^ {56'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
        fb = r[0];
        r  = r >> 1;
        if (fb) r = r ^ eng_cfg.poly_work;
      end
    end else begin
      r = r ^ byte_al;
      for (int i = 0; i < 8; i++) begin
        case (eng_cfg.width_mode)
          WMODE_NARROW: fb = r[7];
          WMODE_16:     fb = r[15];
          WMODE_32:     fb = r[31];
          WMODE_64:     fb = r[63];
          default:      fb = r[63];
        endcase
        r = (r << 1) & mask;
        if (fb) r = r ^ eng_cfg.poly_work;
      end
    end
    crc_next = r & mask;

    // Narrow normal mode shifts the left-aligned CRC back down
    if (eng_cfg.width_mode == WMODE_NARROW && !eng_cfg.reflected)
      crc_out = {56'd0, crc_next[BYTE_W-1:0] >> eng_cfg.narrow_shift};
    else
      crc_out = crc_next;
  end

endmodule

// ===== rtl/core/configurable_crc_byte_engine_unit.sv =====
// Top level of the configurable CRC byte engine: config, input stage, CRC and result registers.
//
// Takes one message byte per clock, except while in_stall holds it, and keeps a running
// CRC; a word marked last passes the input stage register and then yields one result word
// in the result register, held back while that register is stalled. The rate is set by the loop
// from the CRC register through the eight-step fold and back, one byte per cycle.
// Width (1..8, 16, 32, 64 bits), polynomial, seed and bit order come from the config
// port, which is to be written while the engine is idle; the block itself does not enforce
// this. No final XOR or output reflection is applied; the result is right-aligned in the
// selected width. Reset selects 32-bit MSB-first mode with zero polynomial, seed and CRC register.
module configurable_crc_byte_engine_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_wr_en,
  input  logic [ccbe_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [ccbe_pkg::CRC_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ccbe_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                          in_first_byte,
  input  logic                          in_last_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ccbe_pkg::CRC_W-1:0]    out_crc_result
);
  import ccbe_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0] width_mode_r;
  logic [NWID_W-1:0] narrow_width_r;
  logic [CRC_W-1:0]  polynomial_r;
  logic [CRC_W-1:0]  seed_value_r;
  logic              reflected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r   <= WIDTH_MODE_RST;
      narrow_width_r <= NARROW_WIDTH_RST;
      polynomial_r   <= '0;
      seed_value_r   <= '0;
      reflected_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH_MODE:   width_mode_r   <= cfg_wr_data[MODE_W-1:0];
        CFG_NARROW_WIDTH: narrow_width_r <= cfg_wr_data[NWID_W-1:0];
        CFG_POLYNOMIAL:   polynomial_r   <= cfg_wr_data;
        CFG_SEED_VALUE:   seed_value_r   <= cfg_wr_data;
        CFG_REFLECTED:    reflected_r    <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  eng_cfg_t eng_cfg;

  ccbe_prep u_prep (
    .width_mode   (width_mode_r),
    .narrow_width (narrow_width_r),
    .polynomial   (polynomial_r),
    .seed_value   (seed_value_r),
    .reflected    (reflected_r),
    .eng_cfg      (eng_cfg)
  );

  // Input stage and handshake
  logic              s_valid_r;
  logic [BYTE_W-1:0] s_byte_r;
  logic              s_first_r;
  logic              s_last_r;
  logic              out_valid_r;
  logic [CRC_W-1:0]  out_crc_r;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic [CRC_W-1:0]  crc_res;
  logic              out_free;
  logic              stage_go;
  logic              in_take;

  // A word without last flag never needs the result slot
  assign out_free = !out_valid_r || !out_stall;
  assign stage_go = s_valid_r && (!s_last_r || out_free);
  assign in_stall = s_valid_r && !stage_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= in_take || (s_valid_r && !stage_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_byte_r  <= in_data_byte;
      s_first_r <= in_first_byte;
      s_last_r  <= in_last_byte;
    end
  end

  ccbe_fold u_fold (
    .eng_cfg    (eng_cfg),
    .crc_cur    (crc_r),
    .data_byte  (s_byte_r),
    .first_byte (s_first_r),
    .crc_next   (crc_nxt),
    .crc_out    (crc_res)
  );

  // Running CRC register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (stage_go) begin
      crc_r <= crc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_go && s_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && s_last_r) begin
      out_crc_r <= crc_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_result = out_crc_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the configurable CRC byte engine.
`timescale 1ns / 100ps

module tb;
  import ccbe_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1130;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } byte_word_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = CFG_WIDTH_MODE;
  logic [CRC_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                in_first_byte = 1'b0;
  logic                in_last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CRC_W-1:0]    out_crc_result;

  // Byte words waiting to be sent, CRC words waiting to come back
  byte_word_t          byte_words[$];
  logic [CRC_W-1:0]    crc_due[$];

  // Engine settings and running CRC as the checker sees them
  logic [MODE_W-1:0]   cur_mode = WIDTH_MODE_RST;
  logic [NWID_W-1:0]   cur_nwidth = NARROW_WIDTH_RST;
  logic [CRC_W-1:0]    cur_poly = '0;
  logic [CRC_W-1:0]    cur_seed = '0;
  logic                cur_refl = 1'b0;
  logic [CRC_W-1:0]    crc_state = '0;

  int unsigned         lasts_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         errors = 0;
  int unsigned         cycles = 0;
  int unsigned         send_gap = 0;
  int unsigned         send_calm = 0;
  int unsigned         stall_left = 0;
  int unsigned         recv_calm = 0;
  logic                drain_hold = 1'b0;

  configurable_crc_byte_engine_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_crc_result (out_crc_result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- CRC prediction ----

  // Narrow widths run as an 8-bit engine
  function automatic int unsigned crc_engine_bits();
    case (cur_mode)
      WMODE_NARROW: return 8;
      WMODE_16:     return 16;
      WMODE_32:     return 32;
      default:      return 64;
    endcase
  endfunction

  function automatic logic [CRC_W-1:0] crc_bits_mask(int unsigned w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // Left-alignment of a narrow CRC inside 8 bits; widths 8..15 need none
  function automatic int unsigned crc_align_shift();
    if (cur_nwidth >= 4'd8) return 0;
    return 8 - cur_nwidth;
  endfunction

  function automatic logic [CRC_W-1:0] crc_to_working(logic [CRC_W-1:0] v);
    int unsigned w;
    int unsigned s;
    w = crc_engine_bits();
    s = crc_align_shift();
    if (w == 8) begin
      if (cur_refl) return v & (64'hFF >> s);
      return (v << s) & 64'hFF;
    end
    return v & crc_bits_mask(w);
  endfunction

  function automatic logic [CRC_W-1:0] crc_fold_byte(logic [CRC_W-1:0] acc,
                                                     logic [CRC_W-1:0] gen,
                                                     logic [BYTE_W-1:0] b);
    int unsigned w;
    logic [CRC_W-1:0] m;
    logic hit;
    int i;
    w = crc_engine_bits();
    m = crc_bits_mask(w);
    acc &= m;
    if (cur_refl) begin
      acc ^= {56'd0, b};
      for (i = 0; i < 8; i++) begin
        hit = acc[0];
        acc >>= 1;
        if (hit) acc ^= gen;
      end
    end else begin
      acc ^= {56'd0, b} << (w - 8);
      for (i = 0; i < 8; i++) begin
        hit = acc[w-1];
        acc = (acc << 1) & m;
        if (hit) acc ^= gen;
      end
    end
    return acc & m;
  endfunction

  // Fold one accepted word; a last word queues the CRC it must produce
  task automatic predict_crc_word(logic [BYTE_W-1:0] b, logic f, logic l);
    logic [CRC_W-1:0] gen;
    logic [CRC_W-1:0] crc_out;
    gen = crc_to_working(cur_poly);
    if (f) crc_state = crc_to_working(cur_seed);
    crc_state = crc_fold_byte(crc_state, gen, b);
    if (l) begin
      if (crc_engine_bits() == 8)
        crc_out = cur_refl ? (crc_state & 64'hFF) : ((crc_state & 64'hFF) >> crc_align_shift());
      else
        crc_out = crc_state & crc_bits_mask(crc_engine_bits());
      crc_due.push_back(crc_out);
      lasts_sent <= lasts_sent + 1;
    end
  endtask

  // Mostly short idles, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---- Input driver ----
  always @(posedge clk) begin : drive_words
    byte_word_t w;
    logic       took;
    int unsigned in_flight;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_data_byte  <= '0;
      in_first_byte <= 1'b0;
      in_last_byte  <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) predict_crc_word(in_data_byte, in_first_byte, in_last_byte);
      in_flight = lasts_sent - results_seen + ((took && in_last_byte) ? 1 : 0);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (drain_hold && in_flight != 0) begin
          // hold off until every CRC in flight has come back
          in_valid <= 1'b0;
        end else if (byte_words.size() != 0) begin
          w = byte_words.pop_front();
          in_valid      <= 1'b1;
          in_data_byte  <= w.data;
          in_first_byte <= w.first;
          in_last_byte  <= w.last;
          if (send_calm > 0) begin
            send_calm = send_calm - 1;
            send_gap = 0;
          end else if ($urandom_range(0, 99) == 0) begin
            send_calm = $urandom_range(30, 120);
            send_gap = 0;
          end else begin
            send_gap = pick_idle();
          end
          drain_hold = ($urandom_range(0, 79) == 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- Result monitor and receiver stalls ----
  always @(posedge clk) begin : check_results
    logic [CRC_W-1:0] want;
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (crc_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected crc_result word: expected none, actual %h",
                   $time, out_crc_result);
        end else begin
          want = crc_due.pop_front();
          if (want !== out_crc_result) begin
            errors++;
            $display("%0t: crc_result mismatch: expected %h, actual %h",
                     $time, want, out_crc_result);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        if (recv_calm > 0) begin
          recv_calm = recv_calm - 1;
          n = 0;
        end else if ($urandom_range(0, 149) == 0) begin
          recv_calm = $urandom_range(30, 120);
          n = 0;
        end else begin
          n = pick_idle();
        end
        if (n > 0) begin
          stall_left = n - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // ---- Stimulus helpers ----
  task automatic push_word(logic [BYTE_W-1:0] b, logic f, logic l);
    byte_word_t w;
    w.data = b;
    w.first = f;
    w.last = l;
    byte_words.push_back(w);
  endtask

  // Everything sent, every CRC back, then a wait for a trailing non-last byte
  task automatic wait_quiet();
    do @(negedge clk);
    while (byte_words.size() != 0 || in_valid || crc_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CRC_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_WIDTH_MODE:   cur_mode = val[MODE_W-1:0];
      CFG_NARROW_WIDTH: cur_nwidth = val[NWID_W-1:0];
      CFG_POLYNOMIAL:   cur_poly = val;
      CFG_SEED_VALUE:   cur_seed = val;
      CFG_REFLECTED:    cur_refl = val[0];
      default:          ;
    endcase
  endtask

  // Write every register; small ones sometimes carry junk in the unused bits
  task automatic apply_setup(logic [MODE_W-1:0] mode, logic [NWID_W-1:0] nw,
                             logic [CRC_W-1:0] poly, logic [CRC_W-1:0] seed, logic refl);
    logic [CRC_W-1:0] v;
    v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    v[MODE_W-1:0] = mode;
    write_reg(CFG_WIDTH_MODE, v);
    v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    v[NWID_W-1:0] = nw;
    write_reg(CFG_NARROW_WIDTH, v);
    write_reg(CFG_POLYNOMIAL, poly);
    write_reg(CFG_SEED_VALUE, seed);
    v = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    v[0] = refl;
    write_reg(CFG_REFLECTED, v);
  endtask

  function automatic logic [CRC_W-1:0] pick_wide();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // ---- Test sequence ----
  initial begin : run_test
    int unsigned total;
    int unsigned goal;
    int unsigned n;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic carry_open;
    logic broken;
    logic f;
    logic l;
    logic [NWID_W-1:0] nw;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings; the first word continues from the cleared register
    push_word(8'h3C, 1'b0, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    wait_quiet();

    // 32-bit MSB first, two-byte message
    apply_setup(WMODE_32, 4'd8, 64'h04C1_1DB7, 64'hFFFF_FFFF, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);
    wait_quiet();

    // 32-bit LSB first
    apply_setup(WMODE_32, 4'd8, 64'hEDB8_8320, 64'hFFFF_FFFF, 1'b1);
    push_word(8'h80, 1'b1, 1'b1);
    push_word(8'h01, 1'b1, 1'b1);
    wait_quiet();

    // 64-bit MSB first; second word carries on after a result
    apply_setup(WMODE_64, 4'd8, 64'h42F0_E1EB_A9EA_3693, '1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    wait_quiet();

    // 16-bit LSB first
    apply_setup(WMODE_16, 4'd8, 64'hA001, 64'h0, 1'b1);
    push_word(8'h55, 1'b1, 1'b1);
    wait_quiet();

    // one-bit CRC
    apply_setup(WMODE_NARROW, 4'd1, 64'h1, 64'h1, 1'b0);
    push_word(8'hA5, 1'b1, 1'b1);
    wait_quiet();

    // narrow width zero: always a zero CRC
    apply_setup(WMODE_NARROW, 4'd0, 64'hFF, 64'hFF, 1'b0);
    push_word(8'hFF, 1'b1, 1'b1);
    wait_quiet();

    // narrow width above eight behaves as eight
    apply_setup(WMODE_NARROW, 4'd12, 64'h07, 64'h0, 1'b0);
    push_word(8'h31, 1'b1, 1'b1);
    wait_quiet();

    // 5-bit LSB first
    apply_setup(WMODE_NARROW, 4'd5, 64'h15, 64'h1F, 1'b1);
    push_word(8'hC3, 1'b1, 1'b1);
    wait_quiet();

    // 8-bit LSB first; a first flag mid-message restarts from the seed
    apply_setup(WMODE_NARROW, 4'd8, 64'h8C, 64'h0, 1'b1);
    push_word(8'h01, 1'b1, 1'b0);
    push_word(8'hFE, 1'b1, 1'b1);
    wait_quiet();

    // settings change in the middle of a message
    apply_setup(WMODE_32, 4'd8, 64'h04C1_1DB7, 64'hFFFF_FFFF, 1'b0);
    push_word(8'h31, 1'b1, 1'b0);
    wait_quiet();
    apply_setup(WMODE_16, 4'd8, 64'h1021, 64'hFFFF, 1'b0);
    push_word(8'h32, 1'b0, 1'b1);
    wait_quiet();

    // 64-bit LSB first, all-ones polynomial and seed
    apply_setup(WMODE_64, 4'd8, '1, '1, 1'b1);
    push_word(8'hFF, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    wait_quiet();

    // Random phases: fresh settings, then well-formed messages with some broken ones
    total = 0;
    carry_open = 1'b0;
    while (total < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      if (r == 0) nw = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
      else nw = 4'($urandom_range(1, 8));
      apply_setup(MODE_W'($urandom_range(0, 3)), nw, pick_wide(), pick_wide(),
                  1'($urandom_range(0, 1)));
      goal = $urandom_range(60, 140);
      n = 0;
      while (n < goal) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 4);
        else if (r < 95) len = $urandom_range(5, 12);
        else len = $urandom_range(13, 32);
        broken = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          f = (k == 0) && !carry_open;
          l = (k == len - 1);
          if (broken) begin
            f = 1'($urandom_range(0, 1));
            l = 1'($urandom_range(0, 1));
          end
          push_word(8'($urandom_range(0, 255)), f, l);
          n++;
        end
        carry_open = 1'b0;
      end
      // sometimes leave a message open across the settings change
      if ($urandom_range(0, 3) == 0) begin
        push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        n++;
        carry_open = 1'b1;
      end
      total += n;
      wait_quiet();
    end

    repeat (10) @(negedge clk);
    if (errors == 0 && crc_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
